/* rtl/multi_motor_turn_tracking_pid_unit_macros.svh */
// Assertion macros shared by the checker of the motor control unit.
// No dependencies; include by bare file name.
`ifndef MULTI_MOTOR_TURN_TRACKING_PID_UNIT_MACROS_SVH
`define MULTI_MOTOR_TURN_TRACKING_PID_UNIT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define MMTT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define MMTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that stays live through reset.
`define MMTT_ASSERT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/mmtt_pkg.sv */
// Package of the motor control unit: types, codes, constants and helpers.
// No dependencies; used by the top level, front end, queue, back end and checker.
package mmtt_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int CH_ID_W      = 4;
    localparam int QDEPTH       = 2;
    localparam int DIV_STEPS    = 15;
    localparam int CNT_W        = 4;

    localparam logic [23:0] GAIN_P_RST    = 24'd65536;
    localparam logic [23:0] GAIN_I_RST    = 24'd655;
    localparam logic [23:0] GAIN_D_RST    = 24'd655;
    localparam logic [14:0] SMALL_CUR_RST = 15'd10000;
    localparam logic [14:0] LARGE_CUR_RST = 15'd16384;
    localparam logic [14:0] SMALL_RPM_RST = 15'd20000;
    localparam logic [14:0] LARGE_RPM_RST = 15'd9000;

    // Reciprocals for truncating division by 50 (shift 37) and by 5 (shift 35).
    localparam logic [31:0] RECIP_50 = 32'd2748779070;
    localparam logic [32:0] RECIP_5  = 33'd6871947674;

    localparam logic signed [32:0] INT_LIMIT  = 33'sd670433280;
    localparam logic signed [13:0] HALF_TURN  = 14'sd4096;
    localparam logic signed [17:0] TURN_MAX   = 18'sd131071;
    localparam logic signed [17:0] TURN_MIN   = -18'sd131072;
    localparam logic signed [46:0] SPEED_GAIN = 47'sd3000;
    localparam logic signed [38:0] RATE_GAIN  = 39'sd50;

    typedef enum logic [1:0] {
        K_FB,
        K_CMD,
        K_REJ
    } t_kind;

    typedef enum logic [1:0] {
        ST_FEEDBACK = 2'd0,
        ST_COMMAND  = 2'd1,
        ST_REJECT   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CFG_GAIN_P,
        CFG_GAIN_I,
        CFG_GAIN_D,
        CFG_SMALL_MASK,
        CFG_SMALL_CUR,
        CFG_LARGE_CUR,
        CFG_SMALL_RPM,
        CFG_LARGE_RPM
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SPEED,
        S_ERR,
        S_DIV50,
        S_INTEG,
        S_FSUM,
        S_DIV5L,
        S_DIV5H,
        S_DIV5C,
        S_PROP,
        S_INTG,
        S_DERV,
        S_LIMIT,
        S_SCALE,
        S_DIVIDE,
        S_DONE
    } t_bstate;

    typedef struct packed {
        logic [23:0] gain_p;
        logic [23:0] gain_i;
        logic [23:0] gain_d;
        logic [7:0]  small_motor_mask;
        logic [14:0] small_max_current;
        logic [14:0] large_max_current;
        logic [14:0] small_max_rpm;
        logic [14:0] large_max_rpm;
    } t_cfg;

    typedef struct packed {
        t_kind               kind;
        logic [CH_ID_W-1:0]  ch;
        logic                mode;
        logic signed [31:0]  target;
        logic [12:0]         angle;
        logic signed [15:0]  speed;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* rtl/mmtt_in_if.sv */
// Input item channel of the motor control unit: valid/ready handshake and payload.
// No dependencies.
interface mmtt_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [3:0]         motor_id;
    logic               mode;
    logic signed [31:0] target;
    logic [12:0]        feedback_angle;
    logic signed [15:0] feedback_speed;

    modport source (output valid, cmd, motor_id, mode, target, feedback_angle,
                    feedback_speed, input ready);
    modport sink (input valid, cmd, motor_id, mode, target, feedback_angle,
                  feedback_speed, output ready);
endinterface

/* rtl/mmtt_out_if.sv */
// Result item channel of the motor control unit: valid/ready handshake and payload.
// No dependencies.
interface mmtt_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [2:0]         channel;
    logic               frame_select;
    logic [1:0]         frame_slot;
    logic signed [15:0] current_command;
    logic signed [31:0] position;

    modport source (output valid, status, channel, frame_select, frame_slot,
                    current_command, position, input ready);
    modport sink (input valid, status, channel, frame_select, frame_slot,
                  current_command, position, output ready);
endinterface

/* rtl/multi_motor_turn_tracking_pid_unit.sv */
// Top level of the multi-channel motor controller with turn tracking and PID.
// Depends on mmtt_pkg, mmtt_in_if, mmtt_out_if, mmtt_front, mmtt_queue, mmtt_back.
//
// Usage. Input items arrive on i_item with a valid/ready handshake. A feedback
// item (cmd low) stores a channel's speed and angle and updates its turn count;
// a command item (cmd high) runs that channel's PID in velocity or position
// mode. Every item yields exactly one result item on o_result, in order; ids
// outside 1..CHANNELS give a reject result with all other fields zero.
// Gains and limits are written through i_cfg_we/i_cfg_index/i_cfg_data while
// the block is idle; gains apply to every channel, limits per the small mask.
// Flow. A feedback or rejected item passes the queue and the job register
// before its result is registered. A command passes the sequencer states for
// speed, error, divide by 50, integral, filter (velocity mode only), the three
// PID terms, limit and scale, then the one-bit-a-cycle current divider unless
// the output is at its limit. Items are handled one at a time by the
// sequencer.
// Stalls. A two-entry job queue lets the input side keep taking items while a
// result waits in the output register; when the receiver holds ready low the
// result stays put and the sequencer waits with its next result.
// Reset clears all channel state, the queue and the output valid, and loads
// the default gains and limits.
module multi_motor_turn_tracking_pid_unit #(
    parameter int CHANNELS = mmtt_pkg::CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mmtt_in_if.sink     i_item,
    mmtt_out_if.source  o_result,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import mmtt_pkg::*;

    t_cfg   r_cfg;
    t_push  push;
    t_job   head;
    t_qstat qstat;
    logic   pop;

    // Configuration registers: the write lands on the next edge and stays.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p            <= GAIN_P_RST;
            r_cfg.gain_i            <= GAIN_I_RST;
            r_cfg.gain_d            <= GAIN_D_RST;
            r_cfg.small_motor_mask  <= '0;
            r_cfg.small_max_current <= SMALL_CUR_RST;
            r_cfg.large_max_current <= LARGE_CUR_RST;
            r_cfg.small_max_rpm     <= SMALL_RPM_RST;
            r_cfg.large_max_rpm     <= LARGE_RPM_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_P:     r_cfg.gain_p            <= i_cfg_data;
                CFG_GAIN_I:     r_cfg.gain_i            <= i_cfg_data;
                CFG_GAIN_D:     r_cfg.gain_d            <= i_cfg_data;
                CFG_SMALL_MASK: r_cfg.small_motor_mask  <= i_cfg_data[7:0];
                CFG_SMALL_CUR:  r_cfg.small_max_current <= i_cfg_data[14:0];
                CFG_LARGE_CUR:  r_cfg.large_max_current <= i_cfg_data[14:0];
                CFG_SMALL_RPM:  r_cfg.small_max_rpm     <= i_cfg_data[14:0];
                CFG_LARGE_RPM:  r_cfg.large_max_rpm     <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    // The front end classifies each item as it is accepted.
    mmtt_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_item  (i_item),
        .i_qstat (qstat),
        .o_push  (push)
    );

    mmtt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    // The back end owns the channel state and the result register.
    mmtt_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_head   (head),
        .i_qstat  (qstat),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule

/* rtl/mmtt_front.sv */
// Front end: takes input items and classifies them into feedback, command or reject jobs.
// Depends on mmtt_pkg and mmtt_in_if.
module mmtt_front #(
    parameter int CHANNELS = mmtt_pkg::CHANNELS_DEF
) (
    mmtt_in_if.sink         i_item,
    input  mmtt_pkg::t_qstat i_qstat,
    output mmtt_pkg::t_push  o_push
);
    import mmtt_pkg::*;

    logic id_ok;

    // Valid ids run from 1 to CHANNELS; compare one bit wider so 16 fits.
    assign id_ok = (i_item.motor_id != '0) &&
                   ({1'b0, i_item.motor_id} <= 5'(CHANNELS));

    assign i_item.ready = !i_qstat.full;

    always_comb begin
        o_push.valid      = i_item.valid && !i_qstat.full;
        o_push.job.mode   = i_item.mode;
        o_push.job.target = i_item.target;
        o_push.job.angle  = i_item.feedback_angle;
        o_push.job.speed  = i_item.feedback_speed;
        if (!id_ok) begin
            o_push.job.kind = K_REJ;
            o_push.job.ch   = '0;
        end else begin
            o_push.job.kind = i_item.cmd ? K_CMD : K_FB;
            o_push.job.ch   = i_item.motor_id - 4'd1;
        end
    end

endmodule

/* rtl/mmtt_queue.sv */
// Short job queue that decouples the front end from the control back end.
// Depends on mmtt_pkg.
module mmtt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mmtt_pkg::t_push  i_push,
    input  logic             i_pop,
    output mmtt_pkg::t_job   o_head,
    output mmtt_pkg::t_qstat o_qstat
);
    import mmtt_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    t_job          r_mem [QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wp] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.valid) begin
                r_wp <= (r_wp == PW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push.valid) - (PW+1)'(i_pop);
        end
    end

    assign o_head        = r_mem[r_rp];
    assign o_qstat.full  = (r_cnt == (PW+1)'(QDEPTH));
    assign o_qstat.empty = (r_cnt == '0);

endmodule

/* rtl/mmtt_back.sv */
// Back end: per-channel turn tracking and PID sequencer with the result register.
// Depends on mmtt_pkg and mmtt_out_if.
module mmtt_back #(
    parameter int CHANNELS = mmtt_pkg::CHANNELS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mmtt_pkg::t_cfg   i_cfg,
    input  mmtt_pkg::t_job   i_head,
    input  mmtt_pkg::t_qstat i_qstat,
    output logic             o_pop,
    mmtt_out_if.source       o_result
);
    import mmtt_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Channel state.
    logic [12:0]        r_last  [CHANNELS];
    logic               r_seen  [CHANNELS];
    logic signed [17:0] r_turn  [CHANNELS];
    logic signed [15:0] r_speed [CHANNELS];
    logic signed [31:0] r_isum  [CHANNELS];
    logic signed [31:0] r_prev  [CHANNELS];
    logic signed [31:0] r_fst   [CHANNELS];

    t_bstate r_state, n_state;
    t_job    r_job;

    // Working registers.
    logic [14:0]        r_maxrpm, r_maxcur;
    logic signed [31:0] r_sp, r_err, r_int_new, r_filt;
    logic [26:0]        r_q50;
    logic [33:0]        r_fmag;
    logic               r_fneg;
    logic [49:0]        r_pl, r_ph;
    logic signed [57:0] r_acc;
    logic [56:0]        r_pabs;
    logic               r_neg, r_sat;
    logic [14:0]        r_rem, r_dq;
    logic [CNT_W-1:0]   r_cnt;

    // Result register.
    logic               r_ov;
    t_status            r_o_status;
    logic [2:0]         r_o_ch;
    logic signed [15:0] r_o_cur;
    logic signed [31:0] r_o_pos;

    logic               out_free, commit;
    logic [CW-1:0]      ci;
    logic               is_small;
    logic [14:0]        sel_rpm, maxrpm, maxcur;
    logic signed [31:0] pos_cur;
    logic signed [34:0] delta;
    logic signed [46:0] prod3000, lim16;
    logic signed [31:0] sp_next;
    logic signed [32:0] err_diff;
    logic [31:0]        abs_err;
    logic [63:0]        prod50;
    logic signed [32:0] isum_base, q50_ext, isum_raw;
    logic signed [31:0] isum_next;
    logic signed [32:0] ediff;
    logic signed [38:0] d50;
    logic signed [34:0] fsum, fsum_neg;
    logic [66:0]        sum5;
    logic [31:0]        q5;
    logic signed [24:0] mul_g;
    logic signed [31:0] mul_m;
    logic signed [57:0] mul_p, acc_abs;
    logic [61:0]        prod_cur;
    logic [15:0]        r2, r2_sub;
    logic               ge;
    logic [14:0]        cmag;
    logic signed [15:0] cur_cmd;
    logic signed [13:0] adiff;
    logic [12:0]        base_angle;
    logic signed [17:0] turn_new;
    logic signed [31:0] pos_new;

    assign ci       = r_job.ch[CW-1:0];
    assign out_free = !r_ov || o_result.ready;

    // Motor type and limits of the job's channel.
    assign is_small = (r_job.ch < 4'd8) && i_cfg.small_motor_mask[r_job.ch[2:0]];
    assign sel_rpm  = is_small ? i_cfg.small_max_rpm : i_cfg.large_max_rpm;
    assign maxrpm   = (sel_rpm == '0) ? 15'd1 : sel_rpm;
    assign maxcur   = is_small ? i_cfg.small_max_current : i_cfg.large_max_current;

    // Speed target; position mode turns the position error into a clamped speed.
    assign pos_cur  = {r_turn[ci][17], r_turn[ci], r_last[ci]};
    assign delta    = $signed({{3{r_job.target[31]}}, r_job.target}) -
                      $signed({pos_cur, 3'b000});
    assign prod3000 = delta * SPEED_GAIN;
    assign lim16    = $signed({16'd0, maxrpm, 16'd0});

    always_comb begin
        if (!r_job.mode) begin
            sp_next = r_job.target;
        end else if (prod3000 > lim16) begin
            sp_next = lim16[31:0];
        end else if (prod3000 < -lim16) begin
            sp_next = 32'(-lim16);
        end else begin
            sp_next = prod3000[31:0];
        end
    end

    assign err_diff = {r_sp[31], r_sp} - {r_speed[ci][15], r_speed[ci], 16'd0};
    assign abs_err  = r_err[31] ? 32'(-r_err) : r_err;
    assign prod50   = abs_err * RECIP_50;

    // Integral step, truncated toward zero, then clamped.
    assign isum_base = {r_isum[ci][31], r_isum[ci]};
    assign q50_ext   = $signed({6'd0, r_q50});
    assign isum_raw  = r_err[31] ? isum_base - q50_ext : isum_base + q50_ext;

    always_comb begin
        if (isum_raw > INT_LIMIT) begin
            isum_next = 32'(INT_LIMIT);
        end else if (isum_raw < -INT_LIMIT) begin
            isum_next = 32'(-INT_LIMIT);
        end else begin
            isum_next = isum_raw[31:0];
        end
    end

    assign ediff = {r_err[31], r_err} - {r_prev[ci][31], r_prev[ci]};
    assign d50   = ediff * RATE_GAIN;

    // Low-pass filter: (derivative + 4 * old) / 5 through a reciprocal.
    assign fsum     = {{3{r_filt[31]}}, r_filt} + {r_fst[ci][31], r_fst[ci], 2'b00};
    assign fsum_neg = -fsum;
    assign sum5     = {r_ph, 17'd0} + 67'(r_pl);
    assign q5       = sum5[66:35];

    // One shared gain multiplier for the three PID terms.
    always_comb begin
        unique case (r_state)
            S_INTG: begin
                mul_g = $signed({1'b0, i_cfg.gain_i});
                mul_m = r_int_new;
            end
            S_DERV: begin
                mul_g = $signed({1'b0, i_cfg.gain_d});
                mul_m = r_filt;
            end
            default: begin
                mul_g = $signed({1'b0, i_cfg.gain_p});
                mul_m = r_err;
            end
        endcase
    end

    assign mul_p    = mul_g * mul_m;
    assign acc_abs  = r_acc[57] ? -r_acc : r_acc;
    assign prod_cur = r_pabs[46:0] * r_maxcur;

    // Restoring divider step: one quotient bit a cycle.
    assign r2     = {r_rem, r_dq[14]};
    assign ge     = r2 >= {1'b0, r_maxrpm};
    assign r2_sub = r2 - {1'b0, r_maxrpm};

    assign cmag    = r_sat ? r_maxcur : r_dq;
    assign cur_cmd = r_neg ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});

    // Turn tracking on a feedback sample.
    assign base_angle = r_seen[ci] ? r_last[ci] : r_job.angle;
    assign adiff      = $signed({1'b0, base_angle}) - $signed({1'b0, r_job.angle});

    always_comb begin
        turn_new = r_turn[ci];
        if (adiff > HALF_TURN) begin
            if (r_turn[ci] < TURN_MAX) begin
                turn_new = r_turn[ci] + 18'sd1;
            end
        end else if (adiff < -HALF_TURN) begin
            if (r_turn[ci] > TURN_MIN) begin
                turn_new = r_turn[ci] - 18'sd1;
            end
        end
    end

    assign pos_new = {turn_new[17], turn_new, r_job.angle};

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    n_state = (i_head.kind == K_CMD) ? S_SPEED : S_DONE;
                end
            end
            S_SPEED: n_state = S_ERR;
            S_ERR:   n_state = S_DIV50;
            S_DIV50: n_state = S_INTEG;
            S_INTEG: n_state = r_job.mode ? S_PROP : S_FSUM;
            S_FSUM:  n_state = S_DIV5L;
            S_DIV5L: n_state = S_DIV5H;
            S_DIV5H: n_state = S_DIV5C;
            S_DIV5C: n_state = S_PROP;
            S_PROP:  n_state = S_INTG;
            S_INTG:  n_state = S_DERV;
            S_DERV:  n_state = S_LIMIT;
            S_LIMIT: n_state = S_SCALE;
            S_SCALE: n_state = r_sat ? S_DONE : S_DIVIDE;
            S_DIVIDE: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = (r_state == S_IDLE) && !i_qstat.empty;
        commit = (r_state == S_DONE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    r_job <= i_head;
                end
            end
            S_SPEED: begin
                r_maxrpm <= maxrpm;
                r_maxcur <= maxcur;
                r_sp     <= sp_next;
            end
            S_ERR:   r_err <= sat32(64'(err_diff));
            S_DIV50: r_q50 <= prod50[63:37];
            S_INTEG: begin
                r_int_new <= isum_next;
                r_filt    <= sat32(64'(d50));
            end
            S_FSUM: begin
                r_fneg <= fsum[34];
                r_fmag <= fsum[34] ? fsum_neg[33:0] : fsum[33:0];
            end
            S_DIV5L: r_pl <= r_fmag[16:0] * RECIP_5;
            S_DIV5H: r_ph <= r_fmag[33:17] * RECIP_5;
            S_DIV5C: r_filt <= r_fneg ? -$signed(q5) : $signed(q5);
            S_PROP:  r_acc <= mul_p;
            S_INTG:  r_acc <= r_acc + mul_p;
            S_DERV:  r_acc <= r_acc + mul_p;
            S_LIMIT: begin
                r_pabs <= acc_abs[56:0];
                r_neg  <= r_acc[57];
                r_sat  <= acc_abs[56:0] >= {10'd0, r_maxrpm, 32'd0};
            end
            S_SCALE: begin
                r_rem <= prod_cur[61:47];
                r_dq  <= prod_cur[46:32];
                r_cnt <= '0;
            end
            S_DIVIDE: begin
                r_rem <= ge ? r2_sub[14:0] : r2[14:0];
                r_dq  <= {r_dq[13:0], ge};
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Channel state update when the result is handed to the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_last[k]  <= '0;
                r_seen[k]  <= 1'b0;
                r_turn[k]  <= '0;
                r_speed[k] <= '0;
                r_isum[k]  <= '0;
                r_prev[k]  <= '0;
                r_fst[k]   <= '0;
            end
        end else if (commit) begin
            if (r_job.kind == K_FB) begin
                r_last[ci]  <= r_job.angle;
                r_seen[ci]  <= 1'b1;
                r_turn[ci]  <= turn_new;
                r_speed[ci] <= r_job.speed;
            end else if (r_job.kind == K_CMD) begin
                r_isum[ci] <= r_int_new;
                r_prev[ci] <= r_err;
                r_fst[ci]  <= r_filt;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (commit) begin
            r_ov <= 1'b1;
        end else if (o_result.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            unique case (r_job.kind)
                K_FB: begin
                    r_o_status <= ST_FEEDBACK;
                    r_o_ch     <= r_job.ch[2:0];
                    r_o_cur    <= '0;
                    r_o_pos    <= pos_new;
                end
                K_CMD: begin
                    r_o_status <= ST_COMMAND;
                    r_o_ch     <= r_job.ch[2:0];
                    r_o_cur    <= cur_cmd;
                    r_o_pos    <= pos_cur;
                end
                default: begin
                    r_o_status <= ST_REJECT;
                    r_o_ch     <= '0;
                    r_o_cur    <= '0;
                    r_o_pos    <= '0;
                end
            endcase
        end
    end

    assign o_result.valid           = r_ov;
    assign o_result.status          = r_o_status;
    assign o_result.channel         = r_o_ch;
    assign o_result.frame_select    = r_o_ch[2];
    assign o_result.frame_slot      = r_o_ch[1:0];
    assign o_result.current_command = r_o_cur;
    assign o_result.position        = r_o_pos;

endmodule

/* rtl/mmtt_checker.sv */
// Port-level checker for the motor control unit, bound to its top level.
// Depends on mmtt_pkg and multi_motor_turn_tracking_pid_unit_macros.svh.
`include "multi_motor_turn_tracking_pid_unit_macros.svh"

module mmtt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [1:0]  i_status,
    input logic [2:0]  i_channel,
    input logic        i_frame_select,
    input logic [1:0]  i_frame_slot,
    input logic [15:0] i_current_command,
    input logic [31:0] i_position
);
    import mmtt_pkg::*;

    `MMTT_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_status) && $stable(i_current_command) && $stable(i_position), "result changed while stalled")
    `MMTT_ASSERT_NOW(a_reject_clear, i_clk, i_rst_n, i_valid && i_status == ST_REJECT, i_channel == 3'd0 && i_frame_slot == 2'd0 && i_current_command == 16'd0 && i_position == 32'd0, "reject result carries data")
    `MMTT_ASSERT_NOW(a_feedback_frame, i_clk, i_rst_n, i_valid && i_status == ST_FEEDBACK, i_current_command == 16'd0 && i_frame_select == i_channel[2] && i_frame_slot == i_channel[1:0], "feedback result inconsistent")
    `MMTT_ASSERT_RST(a_reset_quiet, i_clk, !i_rst_n, !i_valid, "result valid after reset")

endmodule

bind multi_motor_turn_tracking_pid_unit mmtt_checker u_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (o_result.valid),
    .i_ready           (o_result.ready),
    .i_status          (o_result.status),
    .i_channel         (o_result.channel),
    .i_frame_select    (o_result.frame_select),
    .i_frame_slot      (o_result.frame_slot),
    .i_current_command (o_result.current_command),
    .i_position        (o_result.position)
);
